/* hw/rtl/wpfc_pkg.sv */
// ----------------------------------------------------------------------------
// wpfc_pkg
// Types and constants shared by the weighted pair frequency counter files.
// ----------------------------------------------------------------------------
package wpfc_pkg;

  localparam int unsigned SYM_W          = 5;
  localparam int unsigned WEIGHT_W       = 16;
  localparam int unsigned CFG_W          = 6;
  localparam int unsigned BIN_W          = 33;
  localparam int unsigned FREQ_W         = 17;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned IN_DATA_W      = 32;
  localparam int unsigned OUT_DATA_W     = 24;
  localparam int unsigned STATE_CMP_W    = 7;
  localparam int unsigned IDX_FULL_W     = 14;
  localparam int unsigned NUM_W          = BIN_W + 17;
  localparam int unsigned DIV_CNT_W      = 5;

  localparam logic [CFG_W-1:0]       NUM_STATES_RST = 6'd21;
  localparam logic [STATE_CMP_W-1:0] MIN_STATES     = 7'd2;
  localparam logic [WEIGHT_W-1:0]    ONE_Q15        = 16'd32768;
  localparam logic [FREQ_W-1:0]      ONE_Q16        = 17'd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_ACCUM     = 2'd1,
    CMD_READ_PAIR = 2'd2,
    CMD_READ_SITE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_FIN
  } state_e;

endpackage

/* hw/rtl/weighted_pair_frequency_counter_unit.sv */
// ----------------------------------------------------------------------------
// weighted_pair_frequency_counter_unit
// Weighted pair and single-site histogram with Q1.16 frequency read-out.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tuser carries the command, tdata the two
// symbols and the Q1.15 weight. Results leave on m_axis: tdata carries the
// Q1.16 frequency, tuser the bad-request flag. cfg_we_i writes num_states.
// One word is in flight at a time; s_axis_tready_o is high while waiting.
// Accumulate: memory read, then add and write back; a bad symbol
// gives a flagged result in place of the add step.
// Read: memory read, then the flagged result when flagged; else memory read,
// dividend set-up, the one-bit-per-cycle restoring divider, result load.
// Clear: the accept cycle and then one pair entry (and one site entry)
// zeroed per cycle over all MAX_STATES*MAX_STATES pair entries; the same
// sweep runs after reset, during which no word is accepted.
// Results sit in an output register; the next word is accepted while a
// result waits, and a later result holds in its final state until the
// output register is taken.
// ----------------------------------------------------------------------------
module weighted_pair_frequency_counter_unit #(
  parameter int unsigned MAX_STATES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wpfc_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [4:0] symbol_a, [9:5] symbol_b, [25:10] weight, [31:26] zero
  input  logic [wpfc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [1:0] cmd
  input  logic [wpfc_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [16:0] frequency, [23:17] zero
  output logic [wpfc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] bad_request
  output logic                               m_axis_tuser_o
);
  import wpfc_pkg::*;

  localparam int unsigned DEPTH  = MAX_STATES * MAX_STATES;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned SITE_W = $clog2(MAX_STATES);

  logic [BIN_W-1:0] pair_mem [DEPTH];
  logic [BIN_W-1:0] site_mem [MAX_STATES];

  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       num_states_q;
  logic [BIN_W-1:0]       total_q, total_d;
  logic [IDX_W-1:0]       clr_cnt_q, clr_cnt_d;
  cmd_e                   cmd_q;
  logic                   bad_q;
  logic [WEIGHT_W-1:0]    weight_q;
  logic [IDX_W-1:0]       idx_q;
  logic [SITE_W-1:0]      site_idx_q;
  logic [BIN_W-1:0]       pair_rd_q, site_rd_q;
  logic [BIN_W-1:0]       rem_q, rem_d;
  logic [FREQ_W-1:0]      quo_q, quo_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                   m_valid_q;
  logic [FREQ_W-1:0]      m_freq_q;
  logic                   m_bad_q;

  logic                   s_accept;
  logic                   out_free;
  logic                   out_load;
  logic [FREQ_W-1:0]      out_freq;
  logic                   out_bad;
  logic [SYM_W-1:0]       in_a, in_b;
  logic [WEIGHT_W-1:0]    in_w, in_w_sat;
  logic [STATE_CMP_W-1:0] q_eff, ns_ext, a_ext, b_ext;
  logic                   a_ok, b_ok;
  logic [IDX_FULL_W-1:0]  idx_full;
  logic                   pair_re, site_re;
  logic                   pair_we, site_we;
  logic [IDX_W-1:0]       pair_waddr;
  logic [SITE_W-1:0]      site_waddr;
  logic [BIN_W-1:0]       pair_wdata, site_wdata;
  logic [BIN_W:0]         pair_sum, site_sum, total_sum;
  logic [BIN_W-1:0]       bin_sel;
  logic [NUM_W-1:0]       dividend;
  logic [BIN_W:0]         trial;
  logic                   trial_ge;
  logic [BIN_W:0]         trial_diff;

  assign in_a     = s_axis_tdata_i[SYM_W-1:0];
  assign in_b     = s_axis_tdata_i[2*SYM_W-1:SYM_W];
  assign in_w     = s_axis_tdata_i[2*SYM_W+WEIGHT_W-1:2*SYM_W];
  assign in_w_sat = (in_w > ONE_Q15) ? ONE_Q15 : in_w;

  assign ns_ext = {1'b0, num_states_q};
  assign a_ext  = {2'b00, in_a};
  assign b_ext  = {2'b00, in_b};

  always_comb begin
    if (ns_ext < MIN_STATES) begin
      q_eff = MIN_STATES;
    end else if (ns_ext > STATE_CMP_W'(MAX_STATES)) begin
      q_eff = STATE_CMP_W'(MAX_STATES);
    end else begin
      q_eff = ns_ext;
    end
  end

  assign a_ok     = a_ext < q_eff;
  assign b_ok     = b_ext < q_eff;
  assign idx_full = IDX_FULL_W'(a_ext) * IDX_FULL_W'(MAX_STATES) + IDX_FULL_W'(b_ext);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  assign pair_re = s_accept & a_ok & b_ok;
  assign site_re = s_accept & a_ok;

  assign pair_sum  = {1'b0, pair_rd_q} + (BIN_W+1)'(weight_q);
  assign site_sum  = {1'b0, site_rd_q} + (BIN_W+1)'(weight_q);
  assign total_sum = {1'b0, total_q} + (BIN_W+1)'(weight_q);

  assign bin_sel  = (cmd_q == CMD_READ_SITE) ? site_rd_q : pair_rd_q;
  assign dividend = {1'b0, bin_sel, 16'd0} + NUM_W'(total_q[BIN_W-1:1]);

  assign trial      = {rem_q, quo_q[FREQ_W-1]};
  assign trial_ge   = trial >= {1'b0, total_q};
  assign trial_diff = trial - {1'b0, total_q};

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    clr_cnt_d  = clr_cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    div_cnt_d  = div_cnt_q;
    out_load   = 1'b0;
    out_freq   = '0;
    out_bad    = 1'b0;
    pair_we    = 1'b0;
    site_we    = 1'b0;
    pair_waddr = idx_q;
    site_waddr = site_idx_q;
    pair_wdata = pair_sum[BIN_W] ? {BIN_W{1'b1}} : pair_sum[BIN_W-1:0];
    site_wdata = site_sum[BIN_W] ? {BIN_W{1'b1}} : site_sum[BIN_W-1:0];
    unique case (state_q)
      S_CLEAR: begin
        pair_we    = 1'b1;
        site_we    = 1'b1;
        pair_waddr = clr_cnt_q;
        site_waddr = clr_cnt_q[SITE_W-1:0];
        pair_wdata = '0;
        site_wdata = '0;
        clr_cnt_d  = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          if (cmd_e'(s_axis_tuser_i) == CMD_CLEAR) begin
            state_d   = S_CLEAR;
            clr_cnt_d = '0;
            total_d   = '0;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (cmd_q == CMD_ACCUM && !bad_q) begin
          pair_we = 1'b1;
          site_we = 1'b1;
          total_d = total_sum[BIN_W] ? {BIN_W{1'b1}} : total_sum[BIN_W-1:0];
          state_d = S_IDLE;
        end else if (bad_q || total_q == '0) begin
          if (out_free) begin
            out_load = 1'b1;
            out_bad  = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          rem_d     = dividend[NUM_W-1:FREQ_W];
          quo_d     = dividend[FREQ_W-1:0];
          div_cnt_d = DIV_CNT_W'(FREQ_W - 1);
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        rem_d     = trial_ge ? trial_diff[BIN_W-1:0] : trial[BIN_W-1:0];
        quo_d     = {quo_q[FREQ_W-2:0], trial_ge};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_freq = (quo_q > ONE_Q16) ? ONE_Q16 : quo_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      total_q      <= '0;
      num_states_q <= NUM_STATES_RST;
      div_cnt_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      total_q   <= total_d;
      div_cnt_q <= div_cnt_d;
      if (cfg_we_i) begin
        num_states_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (s_accept) begin
      cmd_q      <= cmd_e'(s_axis_tuser_i);
      bad_q      <= (cmd_e'(s_axis_tuser_i) == CMD_READ_SITE) ? ~a_ok : ~(a_ok & b_ok);
      weight_q   <= in_w_sat;
      idx_q      <= idx_full[IDX_W-1:0];
      site_idx_q <= a_ext[SITE_W-1:0];
    end
    if (out_load) begin
      m_freq_q <= out_freq;
      m_bad_q  <= out_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    if (pair_re) begin
      pair_rd_q <= pair_mem[idx_full[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (site_we) begin
      site_mem[site_waddr] <= site_wdata;
    end
    if (site_re) begin
      site_rd_q <= site_mem[a_ext[SITE_W-1:0]];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - FREQ_W)'(0), m_freq_q};
  assign m_axis_tuser_o  = m_bad_q;

endmodule

/* hw/rtl/wpfc_checker.sv */
// ----------------------------------------------------------------------------
// wpfc_checker
// Port-level checks for the weighted pair frequency counter.
// ----------------------------------------------------------------------------
module wpfc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [wpfc_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input logic                            m_tuser_i
);
  import wpfc_pkg::*;

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> m_tdata_i == '0)
    else $error("flagged result carries a frequency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i <= OUT_DATA_W'(ONE_Q16))
    else $error("frequency above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("second word accepted while one is in flight");

endmodule

bind weighted_pair_frequency_counter_unit wpfc_checker u_wpfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);
